FILE: rtl/core/pes_pkg.sv
// Shared types, codes and constants of the periodic event scheduler.
package pes_pkg;

    // Default number of event slots
    localparam int SLOTS_DEF = 8;

    // Most results that one input item may give
    localparam int MAX_RESULTS = 8;

    // Field widths
    localparam int MODE_W   = 2;
    localparam int HANDLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int KIND_W   = 2;
    localparam int SLOTID_W = 3;

    // Repeat count that never runs out
    localparam logic [TIME_W-1:0] FOREVER = '1;

    // Input item modes
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIRE   = 2'd2;

    // One input item
    typedef struct packed {
        logic [MODE_W-1:0]          mode;
        logic [HANDLE_W-1:0]        handle;
        logic [TIME_W-1:0]          period;
        logic signed [TIME_W-1:0]   repeat_count;
    } t_item;

    // One result item
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic                ok;
        logic [SLOTID_W-1:0] slot;
        logic [HANDLE_W-1:0] fired_handle;
        logic                last;
    } t_result;

    // One slot entry as held in the slot memory
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   period;
        logic [TIME_W-1:0]   deadline;
        logic [TIME_W-1:0]   remaining;
    } t_entry;

endpackage

FILE: rtl/core/periodic_event_scheduler.sv
// Top level of the periodic event scheduler: slot memory, sequencer and output register.
//
//  channel   direction  transfer carries
//  s_axis    in         tick / add / remove item (mode in tuser)
//  m_axis    out        add answer, remove answer or fire (kind in tuser, tlast on final)
//
// An add or remove with a valid handle and a firing tick make the sequencer walk the slot
// memory one slot per cycle while the output does not stall it, then hand over the final
// result. A tick that fires nothing and a rejected add or remove skip the walk.
// Reset (i_rst_n low at a clock edge) frees every slot at once. A stalled output holds the
// walk only when a second result is ready while the first still waits.
module periodic_event_scheduler #(
    parameter int SLOTS = pes_pkg::SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [79:0] i_s_axis_tdata,   // handle[15:0], period[47:16], repeat_count[79:48]
    input  logic [1:0]  i_s_axis_tuser,   // mode[1:0]
    // result items
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // ok[0], slot[3:1], fired_handle[19:4], zero[23:20]
    output logic [1:0]  o_m_axis_tuser,   // kind[1:0]
    output logic        o_m_axis_tlast    // last
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    pes_pkg::t_item   item;
    pes_pkg::t_entry  rd_data;
    pes_pkg::t_entry  wr_data;
    pes_pkg::t_result push_data;
    pes_pkg::t_result out_data;
    logic              rd_en;
    logic              wr_en;
    logic [SLOT_W-1:0] rd_addr;
    logic [SLOT_W-1:0] wr_addr;
    logic              push;
    logic              push_ready;

    // Unpack the input transfer
    assign item.mode         = i_s_axis_tuser;
    assign item.handle       = i_s_axis_tdata[15:0];
    assign item.period       = i_s_axis_tdata[47:16];
    assign item.repeat_count = i_s_axis_tdata[79:48];

    pes_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .o_in_ready   (o_s_axis_tready),
        .i_item       (item),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_push       (push),
        .o_push_data  (push_data),
        .i_push_ready (push_ready)
    );

    pes_slot_mem #(
        .SLOTS (SLOTS)
    ) u_slot_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    pes_out_reg u_out_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .o_valid      (o_m_axis_tvalid),
        .o_data       (out_data),
        .i_ready      (i_m_axis_tready)
    );

    // Pack the output transfer
    assign o_m_axis_tdata = {4'd0, out_data.fired_handle, out_data.slot, out_data.ok};
    assign o_m_axis_tuser = out_data.kind;
    assign o_m_axis_tlast = out_data.last;

endmodule

FILE: rtl/core/pes_slot_mem.sv
// Slot table memory: one write port, one registered read port.
module pes_slot_mem #(
    parameter int SLOTS = pes_pkg::SLOTS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rd_en,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0]  i_rd_addr,
    output pes_pkg::t_entry                               o_rd_data,
    input  logic                                          i_wr_en,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0]  i_wr_addr,
    input  pes_pkg::t_entry                               i_wr_data
);

    pes_pkg::t_entry r_mem [SLOTS];
    pes_pkg::t_entry r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered; data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/pes_out_reg.sv
// Output register stage for result transfers.
module pes_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pes_pkg::t_result i_push_data,
    output logic             o_push_ready,
    output logic             o_valid,
    output pes_pkg::t_result o_data,
    input  logic             i_ready
);

    logic             r_valid;
    logic             n_valid;
    pes_pkg::t_result r_data;

    // Free when empty or when the held result leaves this cycle
    assign o_push_ready = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_push) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data <= i_push_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: rtl/core/pes_ctrl.sv
// Sequencer: walks the slot memory for add, remove and firing ticks, one slot a cycle unless the output stalls.
module pes_ctrl #(
    parameter int SLOTS = pes_pkg::SLOTS_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    // item input
    input  logic                                          i_in_valid,
    output logic                                          o_in_ready,
    input  pes_pkg::t_item                                i_item,
    // slot memory
    output logic                                          o_rd_en,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0]  o_rd_addr,
    input  pes_pkg::t_entry                               i_rd_data,
    output logic                                          o_wr_en,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0]  o_wr_addr,
    output pes_pkg::t_entry                               o_wr_data,
    // result output
    output logic                                          o_push,
    output pes_pkg::t_result                              o_push_data,
    input  logic                                          i_push_ready
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOTS - 1);
    localparam int NRES_W = $clog2(pes_pkg::MAX_RESULTS + 1);
    localparam int TW = pes_pkg::TIME_W;

    // Sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]                     r_state, n_state;
    logic [pes_pkg::MODE_W-1:0]     r_mode, n_mode;
    logic [pes_pkg::HANDLE_W-1:0]   r_h, n_h;
    logic [TW-1:0]                  r_per, n_per;
    logic [TW-1:0]                  r_cnt, n_cnt;
    logic [TW-1:0]                  r_sub, n_sub;
    logic [TW-1:0]                  r_earliest, n_earliest;
    logic [TW-1:0]                  r_elapsed, n_elapsed;
    logic [SLOTS-1:0]               r_used, n_used;
    logic [SLOT_W-1:0]              r_idx, n_idx;
    logic [SLOT_W-1:0]              r_tgt_idx, n_tgt_idx;
    logic                           r_tgt_ok, n_tgt_ok;
    logic                           r_found, n_found;
    logic [SLOT_W-1:0]              r_found_idx, n_found_idx;
    logic                           r_any, n_any;
    logic [TW-1:0]                  r_min, n_min;
    logic [NRES_W-1:0]              r_nres, n_nres;
    pes_pkg::t_result               r_pend, n_pend;
    logic                           r_pend_v, n_pend_v;

    // First free slot
    logic [SLOT_W-1:0] free_idx;
    logic              free_ok;

    always_comb begin
        free_idx = '0;
        free_ok  = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_idx = SLOT_W'(i);
                free_ok  = 1'b1;
            end
        end
    end

    // Per-slot evaluation of the entry read for r_idx
    logic          used_i;
    logic [TW-1:0] dl_rebased;
    logic          fire;
    logic          emit;
    logic          forever_i;
    logic          frees;
    logic [TW-1:0] new_dl;
    logic [TW-1:0] new_rem;
    logic          match;
    logic          cand;
    logic [TW-1:0] cand_val;
    logic          stall;
    logic          advance;
    logic          last_slot;
    logic [TW-1:0] elapsed_inc;
    logic [TW-1:0] earliest_rebased;

    always_comb begin
        used_i     = r_used[r_idx];
        dl_rebased = i_rd_data.deadline - r_sub;
        fire       = (r_mode == pes_pkg::MODE_TICK) && used_i && (dl_rebased == '0);
        emit       = fire && (r_nres < NRES_W'(pes_pkg::MAX_RESULTS));
        forever_i  = (i_rd_data.remaining == pes_pkg::FOREVER);
        frees      = fire && !forever_i && (i_rd_data.remaining <= TW'(1));
        new_dl     = fire ? i_rd_data.period : dl_rebased;
        new_rem    = (fire && !forever_i && !frees) ? (i_rd_data.remaining - TW'(1))
                                                    : i_rd_data.remaining;
        match      = (r_mode == pes_pkg::MODE_REMOVE) && used_i
                     && (i_rd_data.handle == r_h) && !r_found;
        // Survivors that count towards the new earliest deadline
        if (r_mode == pes_pkg::MODE_REMOVE) begin
            cand     = used_i && !match;
            cand_val = i_rd_data.deadline;
        end else begin
            cand     = used_i && !frees;
            cand_val = new_dl;
        end
        stall     = (r_state == ST_WALK) && emit && r_pend_v && !i_push_ready;
        advance   = (r_state == ST_WALK) && !stall;
        last_slot = (r_idx == LAST_IDX);
        elapsed_inc      = r_elapsed + TW'(1);
        earliest_rebased = r_earliest - r_elapsed;
    end

    assign o_in_ready = (r_state == ST_IDLE);

    // Memory reads: slot 0 on acceptance, then the next slot on each step
    assign o_rd_en   = ((r_state == ST_IDLE) && i_in_valid) || (advance && !last_slot);
    assign o_rd_addr = (r_state == ST_IDLE) ? '0 : (r_idx + SLOT_W'(1));

    // Memory write-back of the slot under work
    always_comb begin
        o_wr_en   = 1'b0;
        o_wr_addr = r_idx;
        o_wr_data = i_rd_data;
        if (r_mode == pes_pkg::MODE_ADD) begin
            if (used_i) begin
                o_wr_en            = advance;
                o_wr_data.deadline = dl_rebased;
            end else if (r_tgt_ok && (r_idx == r_tgt_idx)) begin
                o_wr_en             = advance;
                o_wr_data.handle    = r_h;
                o_wr_data.period    = r_per;
                o_wr_data.deadline  = r_per;
                o_wr_data.remaining = r_cnt;
            end
        end else if (r_mode == pes_pkg::MODE_TICK) begin
            o_wr_en             = advance && used_i && !frees;
            o_wr_data.deadline  = new_dl;
            o_wr_data.remaining = new_rem;
        end
    end

    // Result pushes into the output register
    always_comb begin
        o_push      = 1'b0;
        o_push_data = r_pend;
        if (r_state == ST_WALK) begin
            o_push = advance && emit && r_pend_v;
        end else if (r_state == ST_FLUSH) begin
            o_push           = r_pend_v && i_push_ready;
            o_push_data.last = 1'b1;
        end
    end

    // Next state
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_h         = r_h;
        n_per       = r_per;
        n_cnt       = r_cnt;
        n_sub       = r_sub;
        n_earliest  = r_earliest;
        n_elapsed   = r_elapsed;
        n_used      = r_used;
        n_idx       = r_idx;
        n_tgt_idx   = r_tgt_idx;
        n_tgt_ok    = r_tgt_ok;
        n_found     = r_found;
        n_found_idx = r_found_idx;
        n_any       = r_any;
        n_min       = r_min;
        n_nres      = r_nres;
        n_pend      = r_pend;
        n_pend_v    = r_pend_v;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_mode  = i_item.mode;
                    n_h     = i_item.handle;
                    n_per   = i_item.period;
                    n_cnt   = i_item.repeat_count;
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_any   = 1'b0;
                    n_min   = '0;
                    n_nres  = '0;
                    n_pend.kind         = pes_pkg::KIND_ADD;
                    n_pend.ok           = 1'b0;
                    n_pend.slot         = '0;
                    n_pend.fired_handle = i_item.handle;
                    n_pend.last         = 1'b0;
                    case (i_item.mode)
                        pes_pkg::MODE_ADD: begin
                            n_pend_v = 1'b1;
                            if ((i_item.handle == '0) || (i_item.period == '0)) begin
                                n_state = ST_FLUSH;
                            end else begin
                                // Rebase now; the walk shifts the stored deadlines
                                n_sub     = r_elapsed;
                                n_elapsed = '0;
                                n_tgt_idx = free_idx;
                                n_tgt_ok  = free_ok;
                                n_earliest = earliest_rebased;
                                if (free_ok && ((earliest_rebased > i_item.period)
                                                || (earliest_rebased == '0))) begin
                                    n_earliest = i_item.period;
                                end
                                n_pend.ok   = free_ok;
                                n_pend.slot = free_ok ? pes_pkg::SLOTID_W'(free_idx) : '0;
                                n_state     = ST_WALK;
                            end
                        end
                        pes_pkg::MODE_REMOVE: begin
                            n_pend_v = 1'b1;
                            n_pend.kind = pes_pkg::KIND_REMOVE;
                            n_state = (i_item.handle == '0) ? ST_FLUSH : ST_WALK;
                        end
                        pes_pkg::MODE_TICK: begin
                            if (r_earliest != '0) begin
                                if (elapsed_inc < r_earliest) begin
                                    n_elapsed = elapsed_inc;
                                end else begin
                                    n_sub     = elapsed_inc;
                                    n_elapsed = '0;
                                    n_state   = ST_WALK;
                                end
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_WALK: begin
                if (advance) begin
                    // Used bitmap
                    if ((r_mode == pes_pkg::MODE_ADD) && !used_i && r_tgt_ok
                        && (r_idx == r_tgt_idx)) begin
                        n_used[r_idx] = 1'b1;
                    end
                    if (match || frees) begin
                        n_used[r_idx] = 1'b0;
                    end
                    if (match) begin
                        n_found     = 1'b1;
                        n_found_idx = r_idx;
                    end
                    // Running minimum over the surviving slots
                    if (cand) begin
                        n_any = 1'b1;
                        if (!r_any || (cand_val < r_min)) begin
                            n_min = cand_val;
                        end
                    end
                    // Fire result: the held one moves on, the new one is held
                    if (emit) begin
                        n_pend.kind         = pes_pkg::KIND_FIRE;
                        n_pend.ok           = 1'b1;
                        n_pend.slot         = pes_pkg::SLOTID_W'(r_idx);
                        n_pend.fired_handle = i_rd_data.handle;
                        n_pend.last         = 1'b0;
                        n_pend_v            = 1'b1;
                        n_nres              = r_nres + NRES_W'(1);
                    end
                    if (last_slot) begin
                        n_state = ST_FLUSH;
                        if (r_mode != pes_pkg::MODE_ADD) begin
                            n_earliest = n_any ? n_min : '0;
                        end
                        if (r_mode == pes_pkg::MODE_REMOVE) begin
                            n_pend.ok   = n_found;
                            n_pend.slot = n_found ? pes_pkg::SLOTID_W'(n_found_idx) : '0;
                        end
                    end else begin
                        n_idx = r_idx + SLOT_W'(1);
                    end
                end
            end

            ST_FLUSH: begin
                if (!r_pend_v || i_push_ready) begin
                    n_pend_v = 1'b0;
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_earliest <= '0;
            r_elapsed  <= '0;
            r_used     <= '0;
            r_pend_v   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_earliest <= n_earliest;
            r_elapsed  <= n_elapsed;
            r_used     <= n_used;
            r_pend_v   <= n_pend_v;
        end
    end

    // Working registers of the current item
    always_ff @(posedge i_clk) begin
        r_mode      <= n_mode;
        r_h         <= n_h;
        r_per       <= n_per;
        r_cnt       <= n_cnt;
        r_sub       <= n_sub;
        r_idx       <= n_idx;
        r_tgt_idx   <= n_tgt_idx;
        r_tgt_ok    <= n_tgt_ok;
        r_found     <= n_found;
        r_found_idx <= n_found_idx;
        r_any       <= n_any;
        r_min       <= n_min;
        r_nres      <= n_nres;
        r_pend      <= n_pend;
    end

endmodule

FILE: tb/periodic_event_scheduler_tb.sv
// Self-checking testbench of the periodic event scheduler: predicted results vs. the stream.
module periodic_event_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = pes_pkg::SLOTS_DEF;
    // Mode value that the block ignores
    localparam logic [pes_pkg::MODE_W-1:0] MODE_NONE = 2'd3;
    // Repeat count that acts as a very large finite count
    localparam logic [pes_pkg::TIME_W-1:0] COUNT_HUGE = 32'hFFFF_FFFE;

    // Scoreboard: slot table model plus the queue of results still due
    class pes_scoreboard;
        logic [pes_pkg::HANDLE_W-1:0] tbl_handle[SLOTS];
        logic [pes_pkg::TIME_W-1:0]   tbl_period[SLOTS];
        logic [pes_pkg::TIME_W-1:0]   tbl_deadline[SLOTS];
        logic [pes_pkg::TIME_W-1:0]   tbl_left[SLOTS];
        logic [pes_pkg::TIME_W-1:0]   earliest;
        logic [pes_pkg::TIME_W-1:0]   elapsed;
        pes_pkg::t_result             due_results[$];
        int errors, items, adds_placed, removes_found, fires, peak_fires;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                release_slot(i);
            end
            earliest = '0;
            elapsed  = '0;
        endfunction

        function void release_slot(int i);
            tbl_handle[i]   = '0;
            tbl_period[i]   = '0;
            tbl_deadline[i] = '0;
            tbl_left[i]     = '0;
        endfunction

        // Move the time origin to now
        function void shift_to_now();
            for (int i = 0; i < SLOTS; i++) begin
                if (tbl_handle[i] != 0) tbl_deadline[i] -= elapsed;
            end
            earliest -= elapsed;
            elapsed = '0;
        endfunction

        function logic [pes_pkg::TIME_W-1:0] min_deadline();
            logic [pes_pkg::TIME_W-1:0] m;
            bit any;
            m = '0;
            any = 0;
            for (int i = 0; i < SLOTS; i++) begin
                if (tbl_handle[i] != 0 && (!any || tbl_deadline[i] < m)) begin
                    m = tbl_deadline[i];
                    any = 1;
                end
            end
            return m;
        endfunction

        function void queue_answer(logic [pes_pkg::KIND_W-1:0] kind, logic ok, int slot,
                                   logic [pes_pkg::HANDLE_W-1:0] h, logic last);
            pes_pkg::t_result r;
            r.kind         = kind;
            r.ok           = ok;
            r.slot         = pes_pkg::SLOTID_W'(slot);
            r.fired_handle = h;
            r.last         = last;
            due_results.push_back(r);
        endfunction

        // Predict the results of one accepted input transfer
        function void apply_item(pes_pkg::t_item it);
            bit done;
            int n;
            done = 0;
            n = 0;
            if (it.mode != MODE_NONE) items++;
            case (it.mode)
                pes_pkg::MODE_ADD: begin
                    if (it.handle != 0 && it.period != 0) begin
                        shift_to_now();
                        for (int i = 0; i < SLOTS; i++) begin
                            if (!done && tbl_handle[i] == 0) begin
                                tbl_handle[i]   = it.handle;
                                tbl_period[i]   = it.period;
                                tbl_deadline[i] = it.period;
                                tbl_left[i]     = it.repeat_count;
                                if (earliest > it.period || earliest == 0) earliest = it.period;
                                queue_answer(pes_pkg::KIND_ADD, 1'b1, i, it.handle, 1'b1);
                                adds_placed++;
                                done = 1;
                            end
                        end
                    end
                    if (!done) queue_answer(pes_pkg::KIND_ADD, 1'b0, 0, it.handle, 1'b1);
                end
                pes_pkg::MODE_REMOVE: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!done && it.handle != 0 && tbl_handle[i] == it.handle) begin
                            release_slot(i);
                            earliest = min_deadline();
                            queue_answer(pes_pkg::KIND_REMOVE, 1'b1, i, it.handle, 1'b1);
                            removes_found++;
                            done = 1;
                        end
                    end
                    if (!done) queue_answer(pes_pkg::KIND_REMOVE, 1'b0, 0, it.handle, 1'b1);
                end
                pes_pkg::MODE_TICK: begin
                    if (earliest != 0) begin
                        elapsed++;
                        if (elapsed >= earliest) begin
                            shift_to_now();
                            for (int i = 0; i < SLOTS; i++) begin
                                if (tbl_handle[i] != 0 && tbl_deadline[i] == 0) begin
                                    if (n < pes_pkg::MAX_RESULTS) begin
                                        queue_answer(pes_pkg::KIND_FIRE, 1'b1, i,
                                                     tbl_handle[i], 1'b0);
                                        n++;
                                    end
                                    tbl_deadline[i] = tbl_period[i];
                                    if (tbl_left[i] != pes_pkg::FOREVER) begin
                                        if (tbl_left[i] <= 1) release_slot(i);
                                        else tbl_left[i]--;
                                    end
                                end
                            end
                            earliest = min_deadline();
                            if (n > 0) due_results[due_results.size()-1].last = 1'b1;
                            fires += n;
                            if (n > peak_fires) peak_fires = n;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        // Check one accepted output transfer against the oldest prediction
        function void check_result(pes_pkg::t_result got);
            pes_pkg::t_result want;
            if (due_results.size() == 0) begin
                $error("result with none pending: kind %0d slot %0d handle 0x%0h",
                       got.kind, got.slot, got.fired_handle);
                errors++;
                return;
            end
            want = due_results.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("ok", want.ok, got.ok);
            compare_field("slot", want.slot, got.slot);
            compare_field("fired_handle", want.fired_handle, got.fired_handle);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;  // handle[15:0], period[47:16], repeat_count[79:48]
    logic [1:0]  s_tuser = '0;  // mode[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [23:0] m_tdata;       // ok[0], slot[3:1], fired_handle[19:4], zero[23:20]
    logic [1:0]  m_tuser;       // kind[1:0]
    logic        m_tlast;

    bit              src_idle = 1'b1;
    bit              sink_idle = 1'b1;
    int              sink_left = 0;
    logic [15:0]     live_handles[$];
    pes_scoreboard   sb = new();

    periodic_event_scheduler #(.SLOTS(SLOTS)) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    // 10 ns clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result sink back-pressure in random bursts
    always @(posedge clk) begin
        if (sink_left > 0) begin
            sink_left--;
            m_tready <= 1'b0;
        end else if (sink_idle && $urandom_range(0, 4) == 0) begin
            sink_left = $urandom_range(0, 7);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor both channels; results first so a same-edge input cannot hide a stray result
    always @(posedge clk) begin
        pes_pkg::t_item   it;
        pes_pkg::t_result rs;
        if (rst_n) begin
            if (m_tvalid && m_tready) begin
                rs.kind         = m_tuser;
                rs.ok           = m_tdata[0];
                rs.slot         = m_tdata[3:1];
                rs.fired_handle = m_tdata[19:4];
                rs.last         = m_tlast;
                sb.check_result(rs);
            end
            if (s_tvalid && s_tready) begin
                it.mode         = s_tuser;
                it.handle       = s_tdata[15:0];
                it.period       = s_tdata[47:16];
                it.repeat_count = s_tdata[79:48];
                sb.apply_item(it);
            end
        end
    end

    function automatic pes_pkg::t_item mk(logic [pes_pkg::MODE_W-1:0] m,
                                          logic [pes_pkg::HANDLE_W-1:0] h,
                                          logic [pes_pkg::TIME_W-1:0] p,
                                          logic [pes_pkg::TIME_W-1:0] rc);
        pes_pkg::t_item it;
        it.mode         = m;
        it.handle       = h;
        it.period       = p;
        it.repeat_count = rc;
        return it;
    endfunction

    // Offer one item, hold it until the transfer, then maybe leave a gap
    task automatic send(pes_pkg::t_item it);
        s_tvalid <= 1'b1;
        s_tdata  <= {it.repeat_count, it.period, it.handle};
        s_tuser  <= it.mode;
        do @(posedge clk); while (!s_tready);
        if (src_idle && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // Stop offering and wait for the block to drain
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.due_results.size() != 0) @(posedge clk);
        repeat (2 * SLOTS + 4) @(posedge clk);
    endtask

    initial begin
        int n, r;
        logic [15:0] h;
        logic [31:0] p, rc;
        n = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: rejects, unused mode, full table, one-shot, forever, eight fires per tick
        send(mk(pes_pkg::MODE_TICK, 16'h0000, 32'd0, 32'd0));
        send(mk(pes_pkg::MODE_ADD, 16'h0000, 32'd5, pes_pkg::FOREVER));
        send(mk(pes_pkg::MODE_ADD, 16'h0001, 32'd0, pes_pkg::FOREVER));
        send(mk(pes_pkg::MODE_REMOVE, 16'h0000, 32'd0, 32'd0));
        send(mk(pes_pkg::MODE_REMOVE, 16'hABCD, 32'd0, 32'd0));
        send(mk(MODE_NONE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send(mk(pes_pkg::MODE_ADD, 16'hFFFF, 32'd1, 32'd0));
        send(mk(pes_pkg::MODE_ADD, 16'h0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
        for (int i = 2; i < 8; i++) begin
            send(mk(pes_pkg::MODE_ADD, 16'(i), 32'd1, pes_pkg::FOREVER));
        end
        send(mk(pes_pkg::MODE_ADD, 16'h0009, 32'd1, pes_pkg::FOREVER));
        send(mk(pes_pkg::MODE_TICK, 16'h0000, 32'd0, 32'd0));
        send(mk(pes_pkg::MODE_REMOVE, 16'h0001, 32'd0, 32'd0));
        send(mk(pes_pkg::MODE_ADD, 16'h0008, 32'd1, 32'd2));
        send(mk(pes_pkg::MODE_ADD, 16'h0009, 32'd1, COUNT_HUGE));
        send(mk(pes_pkg::MODE_TICK, 16'h0000, 32'd0, 32'd0));
        send(mk(pes_pkg::MODE_TICK, 16'h0000, 32'd0, 32'd0));
        for (int i = 2; i < 5; i++) send(mk(pes_pkg::MODE_REMOVE, 16'(i), 32'd0, 32'd0));

        // Random: mostly ticks and valid adds/removes, some rejects and ignored modes
        while (n < 125) begin
            if (n == 50) drain();
            if (n == 100) begin
                src_idle  <= 1'b0;
                sink_idle <= 1'b0;
            end
            r  = $urandom_range(0, 99);
            h  = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 12));
            p  = ($urandom_range(0, 6) == 0) ? $urandom : $urandom_range(1, 6);
            case ($urandom_range(0, 2))
                0: rc = pes_pkg::FOREVER;
                1: rc = $urandom_range(0, 4);
                default: rc = $urandom;
            endcase
            if (r < 5) begin
                send(mk(MODE_NONE, 16'($urandom), $urandom, $urandom));
            end else begin
                if (r < 50) begin
                    send(mk(pes_pkg::MODE_TICK, 16'($urandom), $urandom, $urandom));
                end else if (r < 78) begin
                    live_handles.push_back(h);
                    send(mk(pes_pkg::MODE_ADD, h, p, rc));
                end else if (r < 83) begin
                    if (r[0]) send(mk(pes_pkg::MODE_ADD, 16'h0000, p, rc));
                    else send(mk(pes_pkg::MODE_ADD, h, 32'd0, rc));
                end else begin
                    if (live_handles.size() != 0 && $urandom_range(0, 9) < 6) begin
                        r = $urandom_range(0, live_handles.size() - 1);
                        h = live_handles[r];
                        live_handles.delete(r);
                    end else begin
                        h = 16'($urandom_range(0, 15));
                    end
                    send(mk(pes_pkg::MODE_REMOVE, h, $urandom, $urandom));
                end
                n++;
            end
        end

        drain();
        $display("ran %0d items: %0d adds placed, %0d removes found, %0d fires",
                 sb.items, sb.adds_placed, sb.removes_found, sb.fires);
        $display("most fires from a single tick: %0d", sb.peak_fires);
        if (sb.errors == 0) begin
            $display("periodic_event_scheduler: match");
        end else begin
            $display("periodic_event_scheduler: mismatch");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(5_000_000);
        $display("periodic_event_scheduler: mismatch");
        $finish;
    end

endmodule
